// ===== rtl/i2cmrc_pkg.sv =====
`default_nettype none

package i2cmrc_pkg;

  localparam int unsigned RegCountDef = 11;
  localparam int unsigned RegIdxW     = 4;

  localparam logic [RegIdxW-1:0] IxCr1  = 4'd0;
  localparam logic [RegIdxW-1:0] IxCr2  = 4'd1;
  localparam logic [RegIdxW-1:0] IxIsr  = 4'd6;
  localparam logic [RegIdxW-1:0] IxIcr  = 4'd7;
  localparam logic [RegIdxW-1:0] IxRxdr = 4'd9;
  localparam logic [RegIdxW-1:0] IxTxdr = 4'd10;

  // ISR bit positions
  localparam int unsigned IsrTxe   = 0;
  localparam int unsigned IsrTxis  = 1;
  localparam int unsigned IsrRxne  = 2;
  localparam int unsigned IsrNackf = 4;
  localparam int unsigned IsrStopf = 5;
  localparam int unsigned IsrTc    = 6;
  localparam int unsigned IsrTcr   = 7;
  localparam int unsigned IsrErrLo = 8;
  localparam int unsigned IsrErrHi = 13;

  // CR1 bit positions
  localparam int unsigned Cr1TcIe  = 6;
  localparam int unsigned Cr1ErrIe = 7;

  // CR2 bit positions
  localparam int unsigned Cr2RdWrn   = 10;
  localparam int unsigned Cr2Start   = 13;
  localparam int unsigned Cr2Stop    = 14;
  localparam int unsigned Cr2NbLo    = 16;
  localparam int unsigned Cr2NbHi    = 23;
  localparam int unsigned Cr2AutoEnd = 25;

  localparam logic [31:0] IsrReset = 32'h0000_0001;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 5;
  localparam int unsigned OutDataW = 64;

  typedef struct packed {
    logic               req_type;
    logic [RegIdxW-1:0] reg_index;
    logic [31:0]        write_data;
    logic               bus_nack;
    logic [7:0]         bus_rx_byte;
    logic               bus_active;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bus_start;
    logic [9:0]  bus_address;
    logic        bus_is_read;
    logic        bus_send;
    logic [7:0]  bus_tx_byte;
    logic        bus_recv;
    logic        bus_stop;
    logic        event_irq;
    logic        error_irq;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/i2c_master_register_controller_top.sv =====
// Path: an accepted item passes through the input register, then decode and
// register-file update into the result register. Throughput: one item per cycle
// while results are taken; the input register refills while the result waits.
// Reset: rst_ni asynchronous, active low; clears the register file (ISR reads TXE),
// shift byte, interrupt lines, split_irq, and both valid flags.
`default_nettype none

module i2c_master_register_controller_top import i2cmrc_pkg::*; #(
  parameter int unsigned RegCount = RegCountDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // write_data[31:0], bus_nack[32], bus_rx_byte[40:33], bus_active[41], zero[47:42]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // req_type[0], reg_index[4:1]
  input  wire logic [InUserW-1:0]  s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // read_data[31:0], bus_start[32], bus_address[42:33], bus_is_read[43],
  // bus_send[44], bus_tx_byte[52:45], bus_recv[53], bus_stop[54],
  // event_irq[55], error_irq[56], zero[63:57]
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res;
  logic      advance;
  logic      take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_item_q.req_type    <= s_axis_tuser[0];
      in_item_q.reg_index   <= s_axis_tuser[4:1];
      in_item_q.write_data  <= s_axis_tdata[31:0];
      in_item_q.bus_nack    <= s_axis_tdata[32];
      in_item_q.bus_rx_byte <= s_axis_tdata[40:33];
      in_item_q.bus_active  <= s_axis_tdata[41];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  i2cmrc_core #(
    .RegCount(RegCount)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .item_i     (in_item_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_o      (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.error_irq, out_q.event_irq, out_q.bus_stop,
                          out_q.bus_recv, out_q.bus_tx_byte, out_q.bus_send,
                          out_q.bus_is_read, out_q.bus_address, out_q.bus_start,
                          out_q.read_data};

endmodule

`default_nettype wire

// ===== rtl/i2cmrc_core.sv =====
`default_nettype none

module i2cmrc_core import i2cmrc_pkg::*; #(
  parameter int unsigned RegCount = RegCountDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire in_item_t  item_i,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_wdata_i,
  output out_item_t      res_o
);

  localparam int unsigned IdxW = $clog2(RegCount);

  logic [31:0]     rf_q [RegCount];
  logic [31:0]     rf_d [RegCount];
  logic [7:0]      shift_q, shift_d;
  logic            event_q, event_d;
  logic            error_q, error_d;
  logic            split_q;

  logic            hit;
  logic [IdxW-1:0] idx;
  logic [7:0]      nb;
  logic [7:0]      nb_dec;
  logic            need_stop;
  logic [7:0]      evt_en;
  out_item_t       res;

  assign hit = {1'b0, item_i.reg_index} < (RegIdxW + 1)'(RegCount);
  assign idx = item_i.reg_index[IdxW-1:0];
  assign nb  = rf_q[IxCr2][Cr2NbHi:Cr2NbLo];
  assign nb_dec = nb - 8'd1;

  always_comb begin
    rf_d      = rf_q;
    shift_d   = shift_q;
    event_d   = event_q;
    error_d   = error_q;
    need_stop = 1'b0;
    evt_en    = '0;
    res       = '0;
    if (hit) begin
      if (!item_i.req_type) begin
        if (item_i.reg_index == IxRxdr && rf_q[IxIsr][IsrRxne]) begin
          rf_d[IxRxdr][7:0] = shift_q;
          if (nb != 8'd0) begin
            rf_d[IxCr2][Cr2NbHi:Cr2NbLo] = nb_dec;
          end
          if (nb > 8'd1 && item_i.bus_active) begin
            shift_d      = item_i.bus_rx_byte;
            res.bus_recv = 1'b1;
          end else begin
            rf_d[IxIsr][IsrRxne] = 1'b0;
            if ((rf_q[IxCr2][Cr2Stop] || rf_q[IxCr2][Cr2AutoEnd]) && item_i.bus_active) begin
              res.bus_stop          = 1'b1;
              rf_d[IxCr2][Cr2Stop]  = 1'b0;
              rf_d[IxIsr][IsrStopf] = 1'b1;
            end
          end
        end
        res.read_data = rf_d[idx];
      end else begin
        rf_d[idx] = item_i.write_data;
        case (item_i.reg_index)
          IxCr2: begin
            if (item_i.write_data[Cr2Start]) begin
              rf_d[IxCr2][Cr2Start] = 1'b0;
              res.bus_start   = 1'b1;
              res.bus_address = item_i.write_data[9:0];
              res.bus_is_read = item_i.write_data[Cr2RdWrn];
              if (item_i.bus_nack) begin
                rf_d[IxIsr][IsrNackf] = 1'b1;
              end else begin
                rf_d[IxIsr][IsrNackf] = 1'b0;
                if (item_i.write_data[Cr2RdWrn]) begin
                  shift_d               = item_i.bus_rx_byte;
                  res.bus_recv          = 1'b1;
                  rf_d[IxIsr][IsrRxne]  = 1'b1;
                  rf_d[IxIsr][IsrTxis]  = 1'b0;
                  rf_d[IxIsr][IsrTxe]   = 1'b0;
                end else begin
                  rf_d[IxIsr][IsrTxis]  = 1'b1;
                  rf_d[IxIsr][IsrTxe]   = 1'b1;
                end
              end
            end
          end
          IxIcr: begin
            rf_d[IxIsr] = rf_q[IxIsr] & ~item_i.write_data;
            rf_d[IxIcr] = '0;
          end
          IxTxdr: begin
            need_stop = rf_q[IxCr2][Cr2Stop];
            if (rf_q[IxIsr][IsrTxe] && item_i.bus_active) begin
              res.bus_send    = 1'b1;
              res.bus_tx_byte = item_i.write_data[7:0];
              rf_d[IxCr2][Cr2NbHi:Cr2NbLo] = nb_dec;
              if (nb_dec == 8'd0) begin
                rf_d[IxIsr][IsrTcr] = 1'b1;
                rf_d[IxIsr][IsrTc]  = 1'b1;
                if (rf_q[IxCr2][Cr2AutoEnd]) begin
                  need_stop = 1'b1;
                end
              end
            end
            if (need_stop) begin
              res.bus_stop          = 1'b1;
              rf_d[IxCr2][Cr2Stop]  = 1'b0;
              rf_d[IxIsr][IsrStopf] = 1'b1;
            end
          end
          default: ;
        endcase
        // TCR shares the TC enable
        evt_en  = {rf_d[IxCr1][Cr1TcIe], rf_d[IxCr1][Cr1TcIe:1], 1'b0};
        event_d = |(rf_d[IxIsr][7:0] & evt_en);
        if (split_q && rf_d[IxCr1][Cr1ErrIe]) begin
          error_d = |rf_d[IxIsr][IsrErrHi:IsrErrLo];
        end
      end
    end
    res.event_irq = event_d;
    res.error_irq = error_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) begin
        rf_q[i] <= (i == int'(IxIsr)) ? IsrReset : '0;
      end
      shift_q <= '0;
      event_q <= 1'b0;
      error_q <= 1'b0;
      split_q <= 1'b0;
    end else begin
      if (fire_i) begin
        rf_q    <= rf_d;
        shift_q <= shift_d;
        event_q <= event_d;
        error_q <= error_d;
      end
      if (cfg_we_i) begin
        split_q <= cfg_wdata_i;
      end
    end
  end

`ifndef SYNTH
  a_read_keeps_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.req_type |=> $stable(event_q) && $stable(error_q))
    else $error("irq lines moved on a read");

  a_error_needs_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(error_q) |-> $past(split_q) && $past(fire_i))
    else $error("error line changed outside split mode");

  a_stop_sets_stopf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.bus_stop |=> rf_q[IxIsr][IsrStopf] && !rf_q[IxCr2][Cr2Stop])
    else $error("stop without STOPF or with STOP left set");

  a_start_fields_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !res.bus_start |-> res.bus_address == '0 && !res.bus_is_read)
    else $error("start fields set without a start");
`endif

endmodule

`default_nettype wire

// ===== sim/i2c_master_register_controller_top_test.sv =====
`default_nettype none

module i2c_master_register_controller_top_test import i2cmrc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 160;
  localparam int unsigned PhaseCount = 8;

  localparam logic ReqRead  = 1'b0;
  localparam logic ReqWrite = 1'b1;

  localparam logic [RegIdxW-1:0] IxPlain   = 4'd3;
  localparam logic [RegIdxW-1:0] IxPastEnd = 4'd11;
  localparam logic [RegIdxW-1:0] IxLast    = 4'd15;

  localparam logic [31:0] EventFlags      = 32'h0000_00FE;
  localparam logic [31:0] Cr1EventEnables = 32'h0000_007E;

  // Register file model and expected result items
  class i2c_reg_scoreboard;
    logic [31:0] regs [RegCountDef];
    logic [7:0]  shift_byte;
    bit          event_line;
    bit          error_line;
    bit          split_irq;
    out_item_t   expected_results [$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[IxIsr] = IsrReset;
      shift_byte  = '0;
      event_line  = 1'b0;
      error_line  = 1'b0;
      split_irq   = 1'b0;
      mismatches  = 0;
      results_seen = 0;
    endfunction

    function void refresh_irq_lines();
      logic [31:0] en;
      logic [31:0] isr;
      en  = regs[IxCr1] & Cr1EventEnables;
      isr = regs[IxIsr];
      if (regs[IxCr1][Cr1TcIe]) en[IsrTcr] = 1'b1;
      if (split_irq) begin
        if (regs[IxCr1][Cr1ErrIe]) error_line = |isr[IsrErrHi:IsrErrLo];
        event_line = |(isr & EventFlags & en);
      end else begin
        // error flags have no enable bit in en, so they never reach the combined line
        event_line = |(isr & en);
      end
    endfunction

    function out_item_t predict_access(in_item_t a);
      out_item_t r;
      logic [7:0] nb;
      logic [RegIdxW-1:0] ix;
      bit stop_req;
      r  = '0;
      ix = a.reg_index;
      if (ix < RegCountDef) begin
        if (a.req_type == ReqRead) begin
          if (ix == IxRxdr && regs[IxIsr][IsrRxne]) begin
            regs[IxRxdr][7:0] = shift_byte;
            nb = regs[IxCr2][Cr2NbHi:Cr2NbLo];
            if (nb != 0) begin
              nb = nb - 8'd1;
              regs[IxCr2][Cr2NbHi:Cr2NbLo] = nb;
            end
            if (nb != 0 && a.bus_active) begin
              shift_byte = a.bus_rx_byte;
              r.bus_recv = 1'b1;
            end else begin
              regs[IxIsr][IsrRxne] = 1'b0;
              if ((regs[IxCr2][Cr2Stop] || regs[IxCr2][Cr2AutoEnd]) && a.bus_active) begin
                r.bus_stop = 1'b1;
                regs[IxCr2][Cr2Stop] = 1'b0;
                regs[IxIsr][IsrStopf] = 1'b1;
              end
            end
          end
          r.read_data = regs[ix];
        end else begin
          regs[ix] = a.write_data;
          if (ix == IxCr2) begin
            if (regs[IxCr2][Cr2Start]) begin
              regs[IxCr2][Cr2Start] = 1'b0;
              r.bus_start   = 1'b1;
              r.bus_address = regs[IxCr2][9:0];
              r.bus_is_read = regs[IxCr2][Cr2RdWrn];
              if (a.bus_nack) begin
                regs[IxIsr][IsrNackf] = 1'b1;
              end else begin
                regs[IxIsr][IsrNackf] = 1'b0;
                if (r.bus_is_read) begin
                  shift_byte = a.bus_rx_byte;
                  r.bus_recv = 1'b1;
                  regs[IxIsr][IsrRxne] = 1'b1;
                  regs[IxIsr][IsrTxis] = 1'b0;
                  regs[IxIsr][IsrTxe]  = 1'b0;
                end else begin
                  regs[IxIsr][IsrTxis] = 1'b1;
                  regs[IxIsr][IsrTxe]  = 1'b1;
                end
              end
            end
          end else if (ix == IxIcr) begin
            regs[IxIsr] = regs[IxIsr] & ~a.write_data;
            regs[IxIcr] = '0;
          end else if (ix == IxTxdr) begin
            stop_req = regs[IxCr2][Cr2Stop];
            if (regs[IxIsr][IsrTxe] && a.bus_active) begin
              nb = regs[IxCr2][Cr2NbHi:Cr2NbLo] - 8'd1;
              r.bus_send    = 1'b1;
              r.bus_tx_byte = a.write_data[7:0];
              regs[IxCr2][Cr2NbHi:Cr2NbLo] = nb;
              if (nb == 0) begin
                regs[IxIsr][IsrTcr] = 1'b1;
                regs[IxIsr][IsrTc]  = 1'b1;
                if (regs[IxCr2][Cr2AutoEnd]) stop_req = 1'b1;
              end
            end
            if (stop_req) begin
              r.bus_stop = 1'b1;
              regs[IxCr2][Cr2Stop] = 1'b0;
              regs[IxIsr][IsrStopf] = 1'b1;
            end
          end
          refresh_irq_lines();
        end
      end
      r.event_irq = event_line;
      r.error_irq = error_line;
      return r;
    endfunction

    function void note_access(in_item_t a);
      expected_results.push_back(predict_access(a));
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: 0x%0h", got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("bus_start", 32'(want.bus_start), 32'(got.bus_start));
      compare_field("bus_address", 32'(want.bus_address), 32'(got.bus_address));
      compare_field("bus_is_read", 32'(want.bus_is_read), 32'(got.bus_is_read));
      compare_field("bus_send", 32'(want.bus_send), 32'(got.bus_send));
      compare_field("bus_tx_byte", 32'(want.bus_tx_byte), 32'(got.bus_tx_byte));
      compare_field("bus_recv", 32'(want.bus_recv), 32'(got.bus_recv));
      compare_field("bus_stop", 32'(want.bus_stop), 32'(got.bus_stop));
      compare_field("event_irq", 32'(want.event_irq), 32'(got.event_irq));
      compare_field("error_irq", 32'(want.error_irq), 32'(got.error_irq));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic                cfg_wdata_i;

  i2c_reg_scoreboard access_sb;
  int unsigned       accepted_count;
  int unsigned       cfg_writes;
  int unsigned       sender_idle_pct;
  int unsigned       receiver_idle_pct;
  bit                quiet;
  bit                hold_output;
  int unsigned       cycle_count;

  i2c_master_register_controller_top dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_wdata_i
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    in_item_t  acc;
    out_item_t res;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc.req_type    = s_axis_tuser[0];
        acc.reg_index   = s_axis_tuser[4:1];
        acc.write_data  = s_axis_tdata[31:0];
        acc.bus_nack    = s_axis_tdata[32];
        acc.bus_rx_byte = s_axis_tdata[40:33];
        acc.bus_active  = s_axis_tdata[41];
        access_sb.note_access(acc);
        accepted_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        res.read_data   = m_axis_tdata[31:0];
        res.bus_start   = m_axis_tdata[32];
        res.bus_address = m_axis_tdata[42:33];
        res.bus_is_read = m_axis_tdata[43];
        res.bus_send    = m_axis_tdata[44];
        res.bus_tx_byte = m_axis_tdata[52:45];
        res.bus_recv    = m_axis_tdata[53];
        res.bus_stop    = m_axis_tdata[54];
        res.event_irq   = m_axis_tdata[55];
        res.error_irq   = m_axis_tdata[56];
        access_sb.check_result(res);
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (120) @(posedge clk_i);
      end else if (!quiet && $urandom_range(99, 0) < receiver_idle_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(8, 1)) @(posedge clk_i);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("i2c_master_register_controller_top: mismatch");
    $finish;
  end

  task automatic issue_access(input logic req, input logic [RegIdxW-1:0] ix,
                              input logic [31:0] data, input logic nack, input logic active);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, active, 8'($urandom), nack, data};
    s_axis_tuser  <= {ix, req};
    do @(posedge clk_i); while (!s_axis_tready);
    if (!quiet && $urandom_range(99, 0) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (access_sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_split_irq(input bit split);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= split;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    access_sb.split_irq = split;
    cfg_writes++;
  endtask

  function automatic logic [31:0] cr2_start_word(logic [9:0] sadd, logic rd, logic [7:0] nb,
                                                  logic autoend, logic stop);
    logic [31:0] w;
    w = $urandom;
    w[9:0]              = sadd;
    w[Cr2RdWrn]         = rd;
    w[Cr2Start]         = 1'b1;
    w[Cr2Stop]          = stop;
    w[Cr2NbHi:Cr2NbLo]  = nb;
    w[Cr2AutoEnd]       = autoend;
    return w;
  endfunction

  task automatic run_transfer();
    logic        rd;
    int unsigned len;
    logic [7:0]  nb;
    rd  = 1'($urandom_range(1, 0));
    len = ($urandom_range(15, 0) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
    nb  = ($urandom_range(9, 0) == 0) ? 8'($urandom) : 8'(len);
    if ($urandom_range(3, 0) == 0) issue_access(ReqWrite, IxCr1, $urandom, 1'b0, 1'b1);
    if ($urandom_range(7, 0) == 0) issue_access(ReqWrite, IxIsr, $urandom, 1'b0, 1'b1);
    issue_access(ReqWrite, IxCr2,
                 cr2_start_word(10'($urandom), rd, nb, 1'($urandom_range(1, 0)),
                                $urandom_range(4, 0) == 0),
                 $urandom_range(9, 0) == 0, 1'b1);
    repeat (len) begin
      if ($urandom_range(7, 0) == 0) issue_access(ReqRead, IxIsr, $urandom, 1'b0, 1'b1);
      issue_access(rd ? ReqRead : ReqWrite, rd ? IxRxdr : IxTxdr, $urandom, 1'b0,
                   $urandom_range(11, 0) != 0);
    end
    if ($urandom_range(2, 0) == 0) issue_access(ReqRead, IxIsr, $urandom, 1'b0, 1'b1);
    if ($urandom_range(1, 0) == 0) issue_access(ReqWrite, IxIcr, $urandom, 1'b0, 1'b1);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(4, 1)) begin
      issue_access(1'($urandom_range(1, 0)),
                   ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 11))
                                               : 4'($urandom_range(10, 0)),
                   $urandom, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    access_sb = new();
    accepted_count = 0;
    cfg_writes = 0;
    quiet = 1'b0;
    hold_output = 1'b0;
    sender_idle_pct = 25;
    receiver_idle_pct = 20;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: combined line first
    issue_access(ReqRead, IxIsr, 32'h0, 1'b0, 1'b0);
    issue_access(ReqWrite, IxCr1, 32'h0000_00FE, 1'b0, 1'b1);
    issue_access(ReqWrite, IxCr2, cr2_start_word(10'h3FF, 1'b0, 8'd2, 1'b1, 1'b0),
                 1'b0, 1'b1);
    issue_access(ReqWrite, IxTxdr, 32'hFFFF_FFFF, 1'b0, 1'b1);
    issue_access(ReqWrite, IxTxdr, 32'h0, 1'b0, 1'b1);       // last byte, autoend stop
    issue_access(ReqRead, IxIsr, 32'h0, 1'b0, 1'b1);
    issue_access(ReqWrite, IxIcr, 32'hFFFF_FFFF, 1'b0, 1'b1);
    issue_access(ReqWrite, IxCr2, cr2_start_word(10'h000, 1'b1, 8'd3, 1'b0, 1'b1),
                 1'b0, 1'b1);
    issue_access(ReqRead, IxRxdr, 32'h0, 1'b0, 1'b1);
    issue_access(ReqRead, IxRxdr, 32'h0, 1'b0, 1'b0);        // ends with bus idle: no stop
    issue_access(ReqRead, IxRxdr, 32'h0, 1'b0, 1'b1);        // RXNE clear: no effect
    issue_access(ReqWrite, IxCr2, cr2_start_word(10'h155, 1'b0, 8'd1, 1'b0, 1'b0),
                 1'b1, 1'b1);                                // NACK
    issue_access(ReqWrite, IxCr2, 32'd1 << Cr2Stop, 1'b0, 1'b1);
    issue_access(ReqWrite, IxTxdr, 32'h0000_00A5, 1'b0, 1'b0); // stop without a byte
    issue_access(ReqWrite, IxIsr, 32'h0000_3F01, 1'b0, 1'b1);
    issue_access(ReqWrite, IxTxdr, 32'h0000_005A, 1'b0, 1'b1); // NBYTES wraps to 255
    issue_access(ReqRead, IxCr2, 32'h0, 1'b0, 1'b1);
    issue_access(ReqWrite, IxPlain, 32'hFFFF_FFFF, 1'b0, 1'b1);
    issue_access(ReqRead, IxPlain, 32'h0, 1'b0, 1'b1);
    issue_access(ReqWrite, IxLast, 32'hFFFF_FFFF, 1'b0, 1'b1);
    issue_access(ReqRead, IxPastEnd, 32'h0, 1'b0, 1'b1);
    issue_access(ReqWrite, IxCr1, 32'h0, 1'b0, 1'b1);
    set_split_irq(1'b1);
    issue_access(ReqWrite, IxCr1, 32'd1 << Cr1ErrIe, 1'b0, 1'b1);
    issue_access(ReqWrite, IxIcr, 32'h0000_3F00, 1'b0, 1'b1);
    issue_access(ReqWrite, IxIsr, 32'h0000_2000, 1'b0, 1'b1);
    issue_access(ReqWrite, IxCr1, 32'h0, 1'b0, 1'b1);       // error line holds

    for (phase = 0; phase < PhaseCount; phase++) begin
      set_split_irq((phase < 6) ? phase[0] : 1'($urandom));
      sender_idle_pct   = (phase == 1) ? 0 : $urandom_range(50, 5);
      receiver_idle_pct = (phase == 1) ? 0 : $urandom_range(50, 5);
      quiet = (phase == PhaseCount - 1);
      if (phase == 3) begin
        sender_idle_pct = 0;
        hold_output = 1'b1;
        repeat (6) run_transfer();
        sender_idle_pct = 20;
      end
      phase_end = accepted_count + PhaseItems;
      while (accepted_count < phase_end) begin
        if (phase == 5 && accepted_count + PhaseItems / 2 == phase_end) drain_results();
        if ($urandom_range(4, 0) == 0) run_noise();
        else run_transfer();
      end
    end

    drain_results();
    $display("%0d register accesses checked across %0d split_irq writes,",
             access_sb.results_seen, cfg_writes);
    $display("covering bus starts, NACKs, sends, receives, stops and IRQ masking.");
    if (access_sb.mismatches == 0 && access_sb.expected_results.size() == 0) begin
      $display("i2c_master_register_controller_top: match");
    end else begin
      $display("i2c_master_register_controller_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
